FILE: hdl/kcdl_pkg.sv
// ----------------------------------------------------------------------------
// kcdl_pkg: keypad code door lock shared definitions
// Commands, modes, notices, register indexes, reset values and the
// state, configuration and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package kcdl_pkg;

	localparam int unsigned CODE_LENGTH_DEF = 4;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned SECS_W  = 6;
	localparam int unsigned NOTE_W  = 3;
	localparam int unsigned CODE_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POWER   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DIGIT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ENTERED = 3'd3;
	localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd4;

	localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ENTRY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOCKOUT = 2'd2;

	localparam logic [NOTE_W-1:0] NOTE_NONE        = 3'd0;
	localparam logic [NOTE_W-1:0] NOTE_UNLOCKED    = 3'd1;
	localparam logic [NOTE_W-1:0] NOTE_WRONG       = 3'd2;
	localparam logic [NOTE_W-1:0] NOTE_TIMEOUT     = 3'd3;
	localparam logic [NOTE_W-1:0] NOTE_LOCKOUT_END = 3'd4;
	localparam logic [NOTE_W-1:0] NOTE_EXIT_OPEN   = 3'd5;
	localparam logic [NOTE_W-1:0] NOTE_CLOSED_IN   = 3'd6;
	localparam logic [NOTE_W-1:0] NOTE_CLOSED_TIME = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_CODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOOR    = 2'd3;

	localparam logic [CODE_W-1:0] CODE_RST    = 16'h5432;
	localparam logic [SECS_W-1:0] ENTRY_RST   = 6'd15;
	localparam logic [SECS_W-1:0] LOCKOUT_RST = 6'd10;
	localparam logic [SECS_W-1:0] DOOR_RST    = 6'd10;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [SECS_W-1:0] entry_secs;
		logic [SECS_W-1:0] lockout_secs;
		logic [SECS_W-1:0] door_secs;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [COUNT_W-1:0] count;
		logic [SECS_W-1:0]  entry_left;
		logic [SECS_W-1:0]  lockout_left;
		logic               door_open;
		logic [SECS_W-1:0]  door_left;
	} lock_state_t;

	typedef struct packed {
		logic               door_open;
		logic [MODE_W-1:0]  lock_mode;
		logic [SECS_W-1:0]  seconds_left;
		logic [COUNT_W-1:0] digits_entered;
		logic [NOTE_W-1:0]  notice;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/kcdl_core.sv
// ----------------------------------------------------------------------------
// kcdl_core: lock step logic
// Next lock state and result for one event, given the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module kcdl_core #(
	parameter int unsigned CODE_LENGTH = kcdl_pkg::CODE_LENGTH_DEF
) (
	input  kcdl_pkg::cfg_t                   cfg,
	input  kcdl_pkg::lock_state_t            cur,
	input  logic [4*CODE_LENGTH-1:0]         cur_code,
	input  logic [kcdl_pkg::CMD_W-1:0]       cmd,
	input  logic [kcdl_pkg::DIGIT_W-1:0]     key_digit,
	output kcdl_pkg::lock_state_t            nxt,
	output logic [4*CODE_LENGTH-1:0]         nxt_code,
	output kcdl_pkg::result_t                res
);
	import kcdl_pkg::*;

	localparam int unsigned ENT_W = 4 * CODE_LENGTH;

	logic [ENT_W-1:0]   shifted;
	logic [COUNT_W-1:0] count_inc;
	logic [NOTE_W-1:0]  lock_note;
	logic [NOTE_W-1:0]  door_note;
	logic [SECS_W-1:0]  secs;

	assign shifted   = (cur_code << 4) | ENT_W'(key_digit);
	assign count_inc = cur.count + COUNT_W'(1);

	always_comb begin
		nxt       = cur;
		nxt_code  = cur_code;
		lock_note = NOTE_NONE;
		door_note = NOTE_NONE;
		unique case (cmd)
			CMD_TICK: begin
				if (cur.mode == MODE_ENTRY) begin
					if (cur.entry_left <= SECS_W'(1)) begin
						nxt.entry_left = cfg.entry_secs;
						nxt.mode       = MODE_LOCKOUT;
						lock_note      = NOTE_TIMEOUT;
					end else begin
						nxt.entry_left = cur.entry_left - SECS_W'(1);
					end
				end else if (cur.mode == MODE_LOCKOUT) begin
					if (cur.lockout_left <= SECS_W'(1)) begin
						nxt.lockout_left = cfg.lockout_secs;
						nxt.mode         = MODE_ENTRY;
						nxt.count        = '0;
						nxt_code         = '0;
						lock_note        = NOTE_LOCKOUT_END;
					end else begin
						nxt.lockout_left = cur.lockout_left - SECS_W'(1);
					end
				end
				if (cur.door_open) begin
					if (cur.door_left <= SECS_W'(1)) begin
						nxt.door_left = cfg.door_secs;
						nxt.door_open = 1'b0;
						door_note     = NOTE_CLOSED_TIME;
					end else begin
						nxt.door_left = cur.door_left - SECS_W'(1);
					end
				end
			end
			CMD_POWER: begin
				if (cur.mode == MODE_OFF) begin
					nxt.mode = MODE_ENTRY;
				end
			end
			CMD_DIGIT: begin
				if (cur.mode == MODE_ENTRY) begin
					if (count_inc >= COUNT_W'(CODE_LENGTH)) begin
						if (shifted == cfg.code[CODE_W-1 -: ENT_W]) begin
							nxt.door_open  = 1'b1;
							nxt.door_left  = cfg.door_secs;
							nxt.entry_left = cfg.entry_secs;
							lock_note      = NOTE_UNLOCKED;
						end else begin
							lock_note = NOTE_WRONG;
						end
						nxt.count = '0;
						nxt_code  = '0;
					end else begin
						nxt.count = count_inc;
						nxt_code  = shifted;
					end
				end
			end
			CMD_ENTERED: begin
				if (cur.door_open) begin
					nxt.door_open = 1'b0;
					nxt.door_left = cfg.door_secs;
					door_note     = NOTE_CLOSED_IN;
				end
			end
			CMD_OPEN: begin
				if (!cur.door_open) begin
					nxt.door_open = 1'b1;
					nxt.door_left = cfg.door_secs;
					door_note     = NOTE_EXIT_OPEN;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique if (nxt.mode == MODE_ENTRY) begin
			secs = nxt.entry_left;
		end else if (nxt.mode == MODE_LOCKOUT) begin
			secs = nxt.lockout_left;
		end else begin
			secs = '0;
		end
	end

	assign res.door_open      = nxt.door_open;
	assign res.lock_mode      = nxt.mode;
	assign res.seconds_left   = secs;
	assign res.digits_entered = nxt.count;
	assign res.notice         = (lock_note != NOTE_NONE) ? lock_note : door_note;

endmodule

`default_nettype wire

FILE: hdl/kcdl_out_reg.sv
// ----------------------------------------------------------------------------
// kcdl_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kcdl_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  kcdl_pkg::result_t load_res,
	output logic              load_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output kcdl_pkg::result_t out_res
);
	import kcdl_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign load_ready = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign out_res    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/keypad_code_door_lock.sv
// ----------------------------------------------------------------------------
// keypad_code_door_lock: event driven keypad door code lock
// Takes tick, power, digit, entered and open events and reports door,
// mode, remaining seconds, digit count and a notice for each event.
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, cmd, key_digit         request in
//   out      out_valid, out_stall, door_open, lock_mode,
//            seconds_left, digits_entered, notice       request out
//   cfg      cfg_we, cfg_index, cfg_data                write in
//
// One request per cycle while out is not stalled; each result goes through
// the input register, then the result register, before out offers it.
// The lock state updates when a request moves from the input register into
// the result register.
// Reset loads default registers and the off state; no clearing pass.
// A stall on out holds the result register and, once the input register is
// also full, raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_door_lock #(
	parameter int unsigned CODE_LENGTH = kcdl_pkg::CODE_LENGTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [kcdl_pkg::CMD_W-1:0]       cmd,
	input  logic [kcdl_pkg::DIGIT_W-1:0]     key_digit,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             door_open,
	output logic [kcdl_pkg::MODE_W-1:0]      lock_mode,
	output logic [kcdl_pkg::SECS_W-1:0]      seconds_left,
	output logic [kcdl_pkg::COUNT_W-1:0]     digits_entered,
	output logic [kcdl_pkg::NOTE_W-1:0]      notice,
	input  logic                             cfg_we,
	input  logic [kcdl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kcdl_pkg::CODE_W-1:0]      cfg_data
);
	import kcdl_pkg::*;

	localparam int unsigned ENT_W = 4 * CODE_LENGTH;

	cfg_t               cfg_q;
	lock_state_t        state_q;
	lock_state_t        state_nxt;
	logic [ENT_W-1:0]   code_q;
	logic [ENT_W-1:0]   code_nxt;
	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [DIGIT_W-1:0] digit_s1;
	logic               adv_ready;
	logic               advance;
	result_t            res_s1;
	result_t            res_out;

	assign advance  = valid_s1 && adv_ready;
	assign in_stall = valid_s1 && !adv_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code         <= CODE_RST;
			cfg_q.entry_secs   <= ENTRY_RST;
			cfg_q.lockout_secs <= LOCKOUT_RST;
			cfg_q.door_secs    <= DOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODE:    cfg_q.code         <= cfg_data;
				REG_ENTRY:   cfg_q.entry_secs   <= cfg_data[SECS_W-1:0];
				REG_LOCKOUT: cfg_q.lockout_secs <= cfg_data[SECS_W-1:0];
				REG_DOOR:    cfg_q.door_secs    <= cfg_data[SECS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= cmd;
			digit_s1 <= key_digit;
		end
	end

	// lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= MODE_OFF;
			state_q.count        <= '0;
			state_q.entry_left   <= ENTRY_RST;
			state_q.lockout_left <= LOCKOUT_RST;
			state_q.door_open    <= 1'b0;
			state_q.door_left    <= DOOR_RST;
			code_q               <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			code_q  <= code_nxt;
		end
	end

	kcdl_core #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_core (
		.cfg      (cfg_q),
		.cur      (state_q),
		.cur_code (code_q),
		.cmd      (cmd_s1),
		.key_digit(digit_s1),
		.nxt      (state_nxt),
		.nxt_code (code_nxt),
		.res      (res_s1)
	);

	kcdl_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(valid_s1),
		.load_res  (res_s1),
		.load_ready(adv_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res_out)
	);

	assign door_open      = res_out.door_open;
	assign lock_mode      = res_out.lock_mode;
	assign seconds_left   = res_out.seconds_left;
	assign digits_entered = res_out.digits_entered;
	assign notice         = res_out.notice;

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count < COUNT_W'(CODE_LENGTH))
		else $error("digit count reached code length");

	a_unlock_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notice == NOTE_UNLOCKED |->
			door_open && digits_entered == '0 && lock_mode == MODE_ENTRY)
		else $error("unlock result inconsistent");

	a_off_no_secs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lock_mode == MODE_OFF |-> seconds_left == '0 && digits_entered == '0)
		else $error("off mode shows seconds or digits");

	a_state_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid && door_open == state_q.door_open
			&& lock_mode == state_q.mode)
		else $error("result register out of step with lock state");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q) && $stable(code_q))
		else $error("lock state changed without a request");

endmodule

`default_nettype wire
